[src/etpc_pkg.sv]
// ----------------------------------------------------------------------------
// etpc_pkg
// Shared types, constants and saturating fixed-point helpers for the
// escape-time point classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package etpc_pkg;

	// Field widths at the ports (fixed)
	localparam int IN_WIDTH      = 32;
	localparam int CFG_IDX_WIDTH = 2;
	localparam int CNT_WIDTH     = 10;

	// Internal fixed-point format
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 24;
	localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
	localparam int WIDE_WIDTH  = 2 * COORD_WIDTH + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [WIDE_WIDTH-1:0]  wide_t;
	typedef logic [CNT_WIDTH-1:0]          cnt_t;

	// Register map
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SEED_REAL = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SEED_IMAG = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_TESTS = 2'd2;

	localparam logic signed [IN_WIDTH-1:0] SEED_REAL_RST = 32'sd27605854;
	localparam logic signed [IN_WIDTH-1:0] SEED_IMAG_RST = 32'sd16164783;
	localparam cnt_t                       MAX_TESTS_RST = 10'd50;

	// Saturation limits, held in the wide format
	localparam wide_t VMAX_W = wide_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam wide_t VMIN_W = -VMAX_W - wide_t'(1);

	function automatic coord_t sat(input wide_t x);
		coord_t r;
		if (x > VMAX_W) begin
			r = VMAX_W[COORD_WIDTH-1:0];
		end else if (x < VMIN_W) begin
			r = VMIN_W[COORD_WIDTH-1:0];
		end else begin
			r = x[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic coord_t sadd(input coord_t a, input coord_t b);
		return sat(wide_t'(a) + wide_t'(b));
	endfunction

	function automatic coord_t ssub(input coord_t a, input coord_t b);
		return sat(wide_t'(a) - wide_t'(b));
	endfunction

	// Raw product -> floor shift by FRAC_BITS -> saturate
	function automatic coord_t pscale(input prod_t p);
		return sat(wide_t'(p >>> FRAC_BITS));
	endfunction

	// 1.0 and 4.0, clamped if the format cannot hold them
	localparam coord_t ONE = sat(wide_t'(1) <<< FRAC_BITS);
	localparam coord_t ESC = sat(wide_t'(4) <<< FRAC_BITS);

	// Datapath commands
	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_SQ,
		CMD_LIN,
		CMD_UV,
		CMD_MC1,
		CMD_MC2,
		CMD_UPD
	} dp_cmd_t;

	typedef struct packed {
		logic escape;
	} dp_status_t;

	typedef struct packed {
		logic                     en;
		logic [CFG_IDX_WIDTH-1:0] index;
		logic [IN_WIDTH-1:0]      data;
	} cfg_wr_t;

	typedef struct packed {
		coord_t seed_real;
		coord_t seed_imag;
		cnt_t   max_tests;
	} cfg_t;

endpackage

`default_nettype wire

[src/etpc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// etpc_cfg_regs
// Configuration register file: map seed and test limit.
// ----------------------------------------------------------------------------
`default_nettype none

module etpc_cfg_regs (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire etpc_pkg::cfg_wr_t  wr,
	output etpc_pkg::cfg_t          cfg
);
	import etpc_pkg::*;

	coord_t seed_real_q;
	coord_t seed_imag_q;
	cnt_t   max_tests_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_real_q <= sat(wide_t'(SEED_REAL_RST));
			seed_imag_q <= sat(wide_t'(SEED_IMAG_RST));
			max_tests_q <= MAX_TESTS_RST;
		end else if (wr.en) begin
			unique case (wr.index)
				REG_SEED_REAL: seed_real_q <= sat(wide_t'($signed(wr.data)));
				REG_SEED_IMAG: seed_imag_q <= sat(wide_t'($signed(wr.data)));
				REG_MAX_TESTS: max_tests_q <= wr.data[CNT_WIDTH-1:0];
				default: ; // unmapped index: ignored
			endcase
		end
	end

	assign cfg.seed_real = seed_real_q;
	assign cfg.seed_imag = seed_imag_q;
	assign cfg.max_tests = max_tests_q;

endmodule

`default_nettype wire

[src/etpc_datapath.sv]
// ----------------------------------------------------------------------------
// etpc_datapath
// Iterate state z, two shared multipliers with registered raw products,
// saturating add/sub and the escape compare.
// ----------------------------------------------------------------------------
`default_nettype none

module etpc_datapath (
	input  wire                                  clk,
	input  wire etpc_pkg::dp_cmd_t               cmd,
	input  wire etpc_pkg::cfg_t                  cfg,
	input  wire signed [etpc_pkg::IN_WIDTH-1:0]  point_real,
	input  wire signed [etpc_pkg::IN_WIDTH-1:0]  point_imag,
	output etpc_pkg::dp_status_t                 status
);
	import etpc_pkg::*;

	coord_t i_q, j_q;
	coord_t a_q, b_q;      // 1 - i, 2i - 1
	coord_t jj_q;          // j*j, kept for u
	coord_t u_q, v_q;
	prod_t  pp0_q, pp1_q;  // raw products
	logic   esc_q;

	coord_t mul0_a, mul0_b, mul1_a, mul1_b;
	coord_t sc0, sc1;

	assign sc0 = pscale(pp0_q);
	assign sc1 = pscale(pp1_q);

	// Operand select for the two multipliers
	always_comb begin
		mul0_a = i_q;
		mul0_b = i_q;
		mul1_a = j_q;
		mul1_b = j_q;
		unique case (cmd)
			CMD_LIN: begin
				mul0_b = a_q;
				mul1_b = b_q;
			end
			CMD_MC1: begin
				mul0_a = cfg.seed_real;
				mul0_b = u_q;
				mul1_a = cfg.seed_imag;
				mul1_b = v_q;
			end
			CMD_MC2: begin
				mul0_a = cfg.seed_imag;
				mul0_b = u_q;
				mul1_a = cfg.seed_real;
				mul1_b = v_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: begin
				i_q <= sat(wide_t'(point_real));
				j_q <= sat(wide_t'(point_imag));
			end
			CMD_SQ: begin
				pp0_q <= prod_t'(mul0_a) * prod_t'(mul0_b);
				pp1_q <= prod_t'(mul1_a) * prod_t'(mul1_b);
				a_q   <= ssub(ONE, i_q);
				b_q   <= ssub(sadd(i_q, i_q), ONE);
			end
			CMD_LIN: begin
				pp0_q <= prod_t'(mul0_a) * prod_t'(mul0_b);
				pp1_q <= prod_t'(mul1_a) * prod_t'(mul1_b);
				jj_q  <= sc1;
				esc_q <= (sadd(sc0, sc1) >= ESC);
			end
			CMD_UV: begin
				u_q <= sadd(jj_q, sc0);
				v_q <= sc1;
			end
			CMD_MC1: begin
				pp0_q <= prod_t'(mul0_a) * prod_t'(mul0_b);
				pp1_q <= prod_t'(mul1_a) * prod_t'(mul1_b);
			end
			CMD_MC2: begin
				pp0_q <= prod_t'(mul0_a) * prod_t'(mul0_b);
				pp1_q <= prod_t'(mul1_a) * prod_t'(mul1_b);
				i_q   <= sadd(sc0, sc1);
			end
			CMD_UPD: begin
				j_q <= ssub(sc0, sc1);
			end
			CMD_NOP: ;
			default: ;
		endcase
	end

	assign status.escape = esc_q;

endmodule

`default_nettype wire

[src/etpc_ctrl.sv]
// ----------------------------------------------------------------------------
// etpc_ctrl
// Sequencer: steps the datapath through one iteration, counts tests,
// raises the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module etpc_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire etpc_pkg::cnt_t         max_tests,
	input  wire etpc_pkg::dp_status_t   status,
	output etpc_pkg::dp_cmd_t           cmd,
	output logic                        busy,
	output logic                        done,
	output logic                        inside_res
);
	import etpc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_LIN,
		ST_UV,
		ST_MC1,
		ST_MC2,
		ST_UPD
	} state_t;

	state_t state_q;
	cnt_t   t_q;
	logic   done_q;
	logic   inside_q;
	logic   go_on;

	// another test is due while t + 1 < max_tests
	assign go_on = ({1'b0, t_q} + (CNT_WIDTH+1)'(1)) < {1'b0, max_tests};

	always_comb begin
		unique case (state_q)
			ST_IDLE: cmd = start ? CMD_LOAD : CMD_NOP;
			ST_TEST: cmd = go_on ? CMD_SQ : CMD_NOP;
			ST_LIN:  cmd = CMD_LIN;
			ST_UV:   cmd = CMD_UV;
			ST_MC1:  cmd = CMD_MC1;
			ST_MC2:  cmd = CMD_MC2;
			ST_UPD:  cmd = CMD_UPD;
			default: cmd = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			t_q      <= '0;
			done_q   <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						t_q     <= '0;
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (go_on) begin
						state_q <= ST_LIN;
					end else begin
						done_q   <= 1'b1;
						inside_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_LIN: state_q <= ST_UV;
				ST_UV: begin
					if (status.escape) begin
						done_q   <= 1'b1;
						inside_q <= 1'b0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_MC1;
					end
				end
				ST_MC1: state_q <= ST_MC2;
				ST_MC2: state_q <= ST_UPD;
				ST_UPD: begin
					t_q     <= t_q + cnt_t'(1);
					state_q <= ST_TEST;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign inside_res = inside_q;

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while sequencer busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held two cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (state_q == ST_IDLE)) |=> (state_q == ST_TEST))
		else $error("accepted point did not start a test");

	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_LOAD) |-> (start && (state_q == ST_IDLE)))
		else $error("datapath load outside an accept");
`endif

endmodule

`default_nettype wire

[src/escape_time_point_classifier.sv]
// ----------------------------------------------------------------------------
// escape_time_point_classifier
// Escape-time classifier for z -> c*z*(1-z) in signed Q8.24 with
// saturation: reports whether a point stays bounded within max_tests tests.
// ----------------------------------------------------------------------------
//
// Channel   Signals                             Handshake
// -------   ---------------------------------   ------------------------------
// point     start, point_real, point_imag       beat when start && !busy
// result    done, inside_res                    one-cycle strobe, no stall
// config    cfg_valid, cfg_index, cfg_data      beat when cfg_valid && cfg_ready
//
// Steps: each iteration runs squares, cross terms, u/v sum with escape
//   check, two seed rounds and update (four rounds on the two shared
//   32x32 multipliers); an escaping point returns earlier than one that
//   runs out of tests. max_tests of 0 or 1 answers with no iteration.
// Busy covers the whole iteration; a new point may be taken in the cycle
//   the result strobe is high.
// Reset: asynchronous, active low; seed and limit return to their reset
//   values, no clearing pass. cfg_ready is always high.
// The receiver cannot stall: done pulses exactly once per point.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_time_point_classifier (
	input  wire                                        clk,
	input  wire                                        arst_n,
	// point channel
	input  wire                                        start,
	output logic                                       busy,
	input  wire signed [etpc_pkg::IN_WIDTH-1:0]        point_real,
	input  wire signed [etpc_pkg::IN_WIDTH-1:0]        point_imag,
	// result channel
	output logic                                       done,
	output logic                                       inside_res,
	// config channel
	input  wire                                        cfg_valid,
	output logic                                       cfg_ready,
	input  wire [etpc_pkg::CFG_IDX_WIDTH-1:0]          cfg_index,
	input  wire [etpc_pkg::IN_WIDTH-1:0]               cfg_data
);
	import etpc_pkg::*;

	cfg_wr_t    cfg_wr;
	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// Register file never stalls a write beat
	assign cfg_ready    = 1'b1;
	assign cfg_wr.en    = cfg_valid & cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	etpc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_wr),
		.cfg    (cfg)
	);

	// Sequencer: owns the test count and the result strobe
	etpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.max_tests  (cfg.max_tests),
		.status     (status),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done),
		.inside_res (inside_res)
	);

	// Datapath: z registers, products, escape flag
	etpc_datapath u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.cfg        (cfg),
		.point_real (point_real),
		.point_imag (point_imag),
		.status     (status)
	);

endmodule

`default_nettype wire
